// ===== design/fpba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared codes for the fit-policy block allocator: commands, policies,
// result status codes, configuration register indexes, reset values and controller states.
// ----------------------------------------------------------------------------
package fpba_pkg;

    // Input command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // Fit policies (the unused code behaves as first fit)
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_LOAD_DONE = 2'd0;
    localparam logic [1:0] ST_ALLOCATED = 2'd1;
    localparam logic [1:0] ST_NO_FIT    = 2'd2;

    // Configuration register indexes
    localparam logic REG_FIT_POLICY    = 1'b0;
    localparam logic REG_ACTIVE_BLOCKS = 1'b1;

    // Reset values of the configuration registers
    localparam logic [1:0] FIT_POLICY_RST    = POL_FIRST;
    localparam logic [4:0] ACTIVE_BLOCKS_RST = 5'd16;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_DONE   = 4'b1000
    } ctrl_state_t;

endpackage

// ===== design/fit_policy_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free-space table per memory block with first, best and worst fit search.
//
//   Channel | Signals                                  | Role
//   --------+------------------------------------------+-----------------------
//   in      | in_valid in_ready cmd block_index size_value | load or alloc request
//   out     | out_valid out_ready status block_number space_left | one result
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data   | register write
//
// A load's result goes to the done state and then to the output register. An
// allocation request scans the active blocks through the table's single read
// port, one entry a cycle, then writes the chosen block back in the update
// state; when nothing fits it goes straight to the done state. The next
// request is taken once the result is in the output register. A result
// the receiver has not taken blocks the next one in the done state.
// Reset clears the table through per-entry valid bits, with no sweep.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [3:0]  block_index,
    input  logic [15:0] size_value,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  block_number,
    output logic [15:0] space_left,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int IW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW  = $clog2(NUM_BLOCKS + 1);
    localparam int LW  = (CW > 5) ? CW : 5;

    // Configuration registers
    logic [1:0]           fit_policy_reg;
    logic [4:0]           active_blocks_reg;

    // Controller state
    ctrl_state_t          state_reg, state_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [CW-1:0]        limit_reg, limit_next;
    logic [CW-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_val_reg, best_val_next;

    // Pending result and output register
    logic [1:0]           res_status_reg, res_status_next;
    logic [3:0]           res_block_reg, res_block_next;
    logic [15:0]          res_space_reg, res_space_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [3:0]           out_block_reg, out_block_next;
    logic [15:0]          out_space_reg, out_space_next;

    // Table ports
    logic                 tbl_wr_en;
    logic [IW-1:0]        tbl_wr_addr;
    logic [SIZE_BITS-1:0] tbl_wr_data;
    logic                 tbl_rd_en;
    logic [IW-1:0]        tbl_rd_addr;
    logic [SIZE_BITS-1:0] tbl_rd_data;

    logic                 in_accept;
    logic                 load_in_range;
    logic [SIZE_BITS-1:0] in_size;
    logic [LW-1:0]        active_ext;
    logic                 cand_fits;
    logic                 cand_better;
    logic [SIZE_BITS-1:0] new_space;

    fpba_table #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (SIZE_BITS),
        .AW    (IW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign in_accept     = in_valid && in_ready;
    assign cfg_ready     = 1'b1;
    assign in_size       = SIZE_BITS'(size_value);
    assign load_in_range = (int'(block_index) < NUM_BLOCKS);
    assign active_ext    = LW'(active_blocks_reg);
    assign new_space     = best_val_reg - size_reg;

    // Candidate compare on the entry read last cycle
    assign cand_fits = (tbl_rd_data >= size_reg);
    always_comb
    begin
        case (fit_policy_reg)
            POL_BEST:  cand_better = (tbl_rd_data < best_val_reg);
            POL_WORST: cand_better = (tbl_rd_data > best_val_reg);
            default:   cand_better = 1'b0;
        endcase
    end

    // Table access: loads and write-back share the write port
    always_comb
    begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = best_idx_reg;
        tbl_wr_data = new_space;
        if (state_reg == S_UPDATE)
        begin
            tbl_wr_en = 1'b1;
        end
        else if (in_accept && (cmd == CMD_LOAD) && load_in_range)
        begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = IW'(block_index);
            tbl_wr_data = in_size;
        end
        tbl_rd_en   = (state_reg == S_SCAN) && (rd_cnt_reg < limit_reg);
        tbl_rd_addr = rd_cnt_reg[IW-1:0];
    end

    // Controller
    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        limit_next      = limit_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_val_next   = best_val_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_space_next  = res_space_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        out_space_next  = out_space_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        res_status_next = ST_LOAD_DONE;
                        res_block_next  = block_index;
                        res_space_next  = load_in_range ? 16'(in_size) : 16'd0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        size_next   = in_size;
                        limit_next  = (active_ext > LW'(NUM_BLOCKS)) ?
                                      CW'(NUM_BLOCKS) : CW'(active_ext);
                        rd_cnt_next = '0;
                        found_next  = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue the next read
                if (tbl_rd_en)
                begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = rd_cnt_reg[IW-1:0];
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                end
                // judge the entry that just came back
                if (rd_pend_reg && cand_fits && (!found_reg || cand_better))
                begin
                    found_next    = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_val_next = tbl_rd_data;
                end
                // all reads issued and judged
                if ((rd_cnt_reg == limit_reg) && !rd_pend_reg)
                begin
                    if (found_reg)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        res_status_next = ST_NO_FIT;
                        res_block_next  = 4'd0;
                        res_space_next  = 16'd0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_UPDATE:
            begin
                res_status_next = ST_ALLOCATED;
                res_block_next  = 4'(best_idx_reg);
                res_space_next  = 16'(new_space);
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_block_next  = res_block_reg;
                    out_space_next  = res_space_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            rd_pend_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            fit_policy_reg    <= FIT_POLICY_RST;
            active_blocks_reg <= ACTIVE_BLOCKS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FIT_POLICY:    fit_policy_reg    <= cfg_data[1:0];
                    REG_ACTIVE_BLOCKS: active_blocks_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        limit_reg      <= limit_next;
        rd_cnt_reg     <= rd_cnt_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_val_reg   <= best_val_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_space_reg  <= res_space_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
        out_space_reg  <= out_space_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign block_number = out_block_reg;
    assign space_left   = out_space_reg;

endmodule

// ===== design/fpba_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_table
// Free-space table: one write port and one read port with registered read
// data. Per-entry valid bits make entries that were never written read as 0.
// ----------------------------------------------------------------------------
module fpba_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] space_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_word_reg;
    logic             rd_valid_reg;

    // Storage array and registered read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            space_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= space_mem[rd_addr];
        end
    end

    // Written flags, cleared at reset so the table starts at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the fit-policy block allocator against a cycle-free predictor of the
// free-space table. Load and allocation requests go in through the request
// channel and each result is compared field by field in arrival order.
// Fit policy and active block count are changed between phases while the
// block is idle. Both channels idle at random, and one long output hold-off
// makes the block stall its input.
// ----------------------------------------------------------------------------
module testbench
    import fpba_pkg::*;
();

    localparam int         STALL_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int         SETTLE_CYCLES = 24;    // idle margin after the last result
    localparam int         HOLD_CYCLES   = 300;
    localparam logic [1:0] POL_UNUSED    = 2'd3;  // behaves as first fit

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  blk;
        logic [15:0] space;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [3:0]  block_index;
    logic [15:0] size_value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [3:0]  block_number;
    logic [15:0] space_left;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [4:0]  cfg_data;

    // predictor state
    logic [15:0]   free_tbl [16];
    logic [1:0]    model_policy;
    logic [4:0]    model_active;
    alloc_result_t pending_results [$];

    int mismatch_count;
    int quiet_cycles;
    int hold_req;
    bit idle_on;

    fit_policy_block_allocator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .block_index  (block_index),
        .size_value   (size_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .block_number (block_number),
        .space_left   (space_left),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected result of one request; updates the table copy.
    function automatic alloc_result_t alloc_predict(input logic op, input logic [3:0] idx,
                                                    input logic [15:0] sz);
        alloc_result_t r;
        int            limit;
        int            pick;
        bit            found;
        r.status = ST_LOAD_DONE;
        r.blk    = idx;
        r.space  = sz;
        if (op == CMD_LOAD)
        begin
            free_tbl[idx] = sz;
            return r;
        end
        limit = (model_active > 5'd16) ? 16 : int'(model_active);
        found = 1'b0;
        pick  = 0;
        for (int j = 0; j < limit; j++)
        begin
            if (free_tbl[j] >= sz)
            begin
                if (!found)
                begin
                    pick  = j;
                    found = 1'b1;
                end
                else if (model_policy == POL_BEST && free_tbl[j] < free_tbl[pick])
                    pick = j;
                else if (model_policy == POL_WORST && free_tbl[j] > free_tbl[pick])
                    pick = j;
            end
        end
        if (found)
        begin
            free_tbl[pick] = free_tbl[pick] - sz;
            r.status       = ST_ALLOCATED;
            r.blk          = 4'(pick);
            r.space        = free_tbl[pick];
        end
        else
        begin
            r.status = ST_NO_FIT;
            r.blk    = 4'd0;
            r.space  = 16'd0;
        end
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    // Monitor: config writes, accepted requests and results, in that order
    always @(posedge clk)
    begin : monitor
        alloc_result_t exp_r;
        bit            moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                if (cfg_index == REG_FIT_POLICY)
                    model_policy = cfg_data[1:0];
                else
                    model_active = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                pending_results.push_back(alloc_predict(cmd, block_index, size_value));
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                    log_mismatch($sformatf("unexpected result status=%0d block=%0d space=%0h",
                                           status, block_number, space_left));
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (status !== exp_r.status || block_number !== exp_r.blk ||
                        space_left !== exp_r.space)
                        log_mismatch($sformatf(
                            "expected status=%0d block=%0d space=%0h, got %0d %0d %0h",
                            exp_r.status, exp_r.blk, exp_r.space,
                            status, block_number, space_left));
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // Watchdog on handshake activity
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("fit_policy_block_allocator test failed");
        $finish;
    end

    // Result side: random stall bursts and the long hold-off
    initial
    begin : receiver
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one request and wait for it to be taken; valid stays high after.
    task automatic send_item(input logic op, input logic [3:0] idx, input logic [15:0] sz);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        block_index <= idx;
        size_value  <= sz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random request, shaped so many allocations actually fit
    task automatic send_random_item();
        logic [3:0]  idx;
        logic [15:0] sz;
        logic [15:0] held;
        idx = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 40)
        begin
            case ($urandom_range(0, 3))
                0:       sz = 16'($urandom);
                1:       sz = 16'($urandom_range(0, 255));
                2:       sz = 16'($urandom_range(0, 7));
                default: sz = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            endcase
            send_item(CMD_LOAD, idx, sz);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: sz = 16'($urandom);
                1: sz = 16'($urandom_range(0, 64));
                2: sz = 16'd0;
                default:
                begin
                    held = free_tbl[$urandom_range(0, 15)];
                    sz   = (held > 16'd4) ? held - 16'($urandom_range(0, 4)) : held;
                end
            endcase
            send_item(CMD_REQUEST, idx, sz);
        end
    endtask

    // Extremes, each policy and the corner cases of the search
    task automatic test_directed_cases();
        // empty table: zero size fits block 0, anything else fails
        send_item(CMD_REQUEST, 4'h0, 16'h0000);
        send_item(CMD_REQUEST, 4'ha, 16'h0001);
        send_item(CMD_LOAD,    4'hf, 16'hffff);
        send_item(CMD_LOAD,    4'h0, 16'h0001);
        send_item(CMD_LOAD,    4'h5, 16'h8000);
        send_item(CMD_LOAD,    4'h9, 16'h8000);
        send_item(CMD_REQUEST, 4'hf, 16'hffff);
        send_item(CMD_REQUEST, 4'h0, 16'h0001);
        send_item(CMD_REQUEST, 4'h0, 16'h0000);
        settle();
        // best fit with a tie between blocks 3 and 7
        write_reg(REG_FIT_POLICY, {3'b000, POL_BEST});
        send_item(CMD_LOAD,    4'h3, 16'h0100);
        send_item(CMD_LOAD,    4'h7, 16'h0100);
        send_item(CMD_REQUEST, 4'h0, 16'h00ff);
        send_item(CMD_REQUEST, 4'h0, 16'h0100);
        settle();
        // worst fit, tie between blocks 5 and 9, then a zero-size request
        write_reg(REG_FIT_POLICY, {3'b000, POL_WORST});
        send_item(CMD_REQUEST, 4'h0, 16'h1000);
        send_item(CMD_REQUEST, 4'h0, 16'h0000);
        settle();
        // unused policy code, upper data bits set
        write_reg(REG_FIT_POLICY, {3'b111, POL_UNUSED});
        send_item(CMD_REQUEST, 4'h0, 16'h0001);
        settle();
        // no active blocks; loads still reach the whole table
        write_reg(REG_ACTIVE_BLOCKS, 5'd0);
        send_item(CMD_REQUEST, 4'h0, 16'h0000);
        send_item(CMD_LOAD,    4'hc, 16'h1234);
        settle();
        write_reg(REG_ACTIVE_BLOCKS, 5'd1);
        send_item(CMD_REQUEST, 4'h0, 16'h0000);
        send_item(CMD_REQUEST, 4'h0, 16'h1234);
        settle();
        // counts above the table size saturate
        write_reg(REG_ACTIVE_BLOCKS, 5'd31);
        send_item(CMD_REQUEST, 4'h0, 16'h1234);
        settle();
        write_reg(REG_ACTIVE_BLOCKS, 5'd17);
        send_item(CMD_REQUEST, 4'h0, 16'h0fff);
        settle();
    endtask

    // Several policy / block-count settings, random traffic in each
    task automatic test_random_phases();
        logic [1:0] pol;
        logic [4:0] act;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       pol = POL_FIRST;
                1:       pol = POL_BEST;
                2:       pol = POL_WORST;
                default: pol = 2'($urandom_range(0, 3));
            endcase
            case (phase)
                0:       act = 5'd16;
                1:       act = 5'd1;
                2:       act = 5'd16;
                3:       act = 5'($urandom_range(0, 31));
                4:       act = 5'($urandom_range(2, 15));
                default: act = 5'd20;
            endcase
            write_reg(REG_FIT_POLICY, {3'($urandom), pol});
            write_reg(REG_ACTIVE_BLOCKS, act);
            repeat (110) send_random_item();
            settle();
        end
    endtask

    // Receiver holds off long enough for the input to back up
    task automatic test_output_backpressure();
        write_reg(REG_FIT_POLICY, {3'b000, POL_BEST});
        write_reg(REG_ACTIVE_BLOCKS, 5'd16);
        hold_req = HOLD_CYCLES;
        repeat (20) send_random_item();
        settle();
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_streaming();
        idle_on = 1'b0;
        write_reg(REG_FIT_POLICY, {3'b000, POL_WORST});
        write_reg(REG_ACTIVE_BLOCKS, 5'd16);
        repeat (250) send_random_item();
        settle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_LOAD;
        block_index    = 4'd0;
        size_value     = 16'd0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_FIT_POLICY;
        cfg_data       = 5'd0;
        model_policy   = FIT_POLICY_RST;
        model_active   = ACTIVE_BLOCKS_RST;
        mismatch_count = 0;
        quiet_cycles   = 0;
        hold_req       = 0;
        idle_on        = 1'b1;
        for (int j = 0; j < 16; j++)
            free_tbl[j] = 16'd0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_phases();
        test_output_backpressure();
        test_streaming();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("fit_policy_block_allocator test passed");
        else
            $display("fit_policy_block_allocator test failed");
        $finish;
    end

endmodule
